>>> src/stereo_highpass_lowpass_biquad_defines.svh
// Assertion helpers shared by the biquad RTL.
// Each helper samples on clock and is disabled while reset is high.
`ifndef STEREO_HIGHPASS_LOWPASS_BIQUAD_DEFINES_SVH
`define STEREO_HIGHPASS_LOWPASS_BIQUAD_DEFINES_SVH

// Condition must hold at every edge.
`define SHB_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SHB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/shb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shb_pkg;

   // Fixed-point format of coefficients and internal samples
   localparam int COEF_FRAC_BITS  = 30;
   localparam int GUARD_FRAC_BITS = 8;

   // One rounded product, and the sum of five of them
   localparam int TERM_W = 65 - COEF_FRAC_BITS;
   localparam int ACC_W  = TERM_W + 3;

   // Register map of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_HP_NUM_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HP_FB_ONE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HP_FB_TWO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LP_NUM_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LP_FB_ONE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LP_FB_TWO   = 3'd5;

   typedef struct packed {
      logic signed [31:0] hp_b0;
      logic signed [31:0] hp_a1;
      logic signed [31:0] hp_a2;
      logic signed [31:0] lp_b0;
      logic signed [31:0] lp_a1;
      logic signed [31:0] lp_a2;
   } coef_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } lane_stat_type;

endpackage

`default_nettype wire

>>> src/shb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module shb_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [15:0]   sample,
   input  wire logic                 clear,
   input  wire shb_pkg::coef_type    coef,
   input  wire logic                 ack,
   output shb_pkg::lane_stat_type    stat,
   output logic signed [15:0]        result
);
   import shb_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ISSUE = 3'd1;
   localparam logic [2:0] PH_DRAIN = 3'd2;
   localparam logic [2:0] PH_FIN   = 3'd3;
   localparam logic [2:0] PH_OUT   = 3'd4;
   localparam logic [2:0] PH_HOLD  = 3'd5;

   localparam logic [2:0] TERM_X0 = 3'd0;
   localparam logic [2:0] TERM_X1 = 3'd1;
   localparam logic [2:0] TERM_X2 = 3'd2;
   localparam logic [2:0] TERM_Y1 = 3'd3;
   localparam logic [2:0] TERM_Y2 = 3'd4;

   localparam logic signed [63:0] HALF_FULL = 64'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [63:0] HALF_MID  = 64'sd1 <<< (COEF_FRAC_BITS - 2);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-32){1'b1}}, 32'h80000000};
   localparam logic [31:0] GUARD_MASK = (32'd1 << GUARD_FRAC_BITS) - 32'd1;

   typedef struct packed {
      logic first;
      logic last;
      logic mid;
      logic neg;
   } tag_type;

   logic [2:0]                phase_ff, phase_in;
   logic                      stage_ff, stage_in;
   logic [2:0]                term_ff, term_in;
   logic signed [31:0]        x_ff, x_in;
   logic signed [31:0]        hp_h_ff [4];
   logic signed [31:0]        hp_h_in [4];
   logic signed [31:0]        lp_h_ff [4];
   logic signed [31:0]        lp_h_in [4];
   logic                      mul_v_ff, mul_v_in;
   tag_type                   mtag_ff, mtag_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic                      rnd_v_ff, rnd_v_in;
   tag_type                   rtag_ff, rtag_in;
   logic signed [TERM_W-1:0]  rnd_ff, rnd_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [15:0]        res_ff, res_in;

   logic signed [31:0]        op_coef, op_data, x_scaled, y_sat, q_out;
   logic signed [31:0]        h0, h1, h2, h3;
   logic signed [63:0]        rnd_full, rnd_mid;
   logic signed [ACC_W-1:0]   term_ext;
   tag_type                   issue_tag;

   assign x_scaled = 32'(sample) <<< GUARD_FRAC_BITS;

   assign h0 = stage_ff ? lp_h_ff[0] : hp_h_ff[0];
   assign h1 = stage_ff ? lp_h_ff[1] : hp_h_ff[1];
   assign h2 = stage_ff ? lp_h_ff[2] : hp_h_ff[2];
   assign h3 = stage_ff ? lp_h_ff[3] : hp_h_ff[3];

   // Operand select for the shared multiplier
   always_comb begin
      issue_tag.first = (term_ff == TERM_X0);
      issue_tag.last  = (term_ff == TERM_Y2);
      issue_tag.mid   = (term_ff == TERM_X1);
      issue_tag.neg   = 1'b0;
      case (term_ff)
         TERM_X1: begin
            op_coef       = stage_ff ? coef.lp_b0 : coef.hp_b0;
            op_data       = h0;
            issue_tag.neg = ~stage_ff;
         end
         TERM_X2: begin
            op_coef = stage_ff ? coef.lp_b0 : coef.hp_b0;
            op_data = h1;
         end
         TERM_Y1: begin
            op_coef       = stage_ff ? coef.lp_a1 : coef.hp_a1;
            op_data       = h2;
            issue_tag.neg = 1'b1;
         end
         TERM_Y2: begin
            op_coef       = stage_ff ? coef.lp_a2 : coef.hp_a2;
            op_data       = h3;
            issue_tag.neg = 1'b1;
         end
         default: begin
            op_coef = stage_ff ? coef.lp_b0 : coef.hp_b0;
            op_data = x_ff;
         end
      endcase
   end

   // Round half up; the doubled middle term drops one fractional bit less
   assign rnd_full = (prod_ff + HALF_FULL) >>> COEF_FRAC_BITS;
   assign rnd_mid  = (prod_ff + HALF_MID) >>> (COEF_FRAC_BITS - 1);
   assign term_ext = ACC_W'(rnd_ff);

   always_comb begin
      if (acc_ff > ACC_MAX) begin
         y_sat = 32'sh7fffffff;
      end else if (acc_ff < ACC_MIN) begin
         y_sat = 32'sh80000000;
      end else begin
         y_sat = acc_ff[31:0];
      end
   end

   // Truncate toward zero on the way out
   always_comb begin
      q_out = x_ff >>> GUARD_FRAC_BITS;
      if (x_ff[31] && ((x_ff & GUARD_MASK) != 32'd0)) begin
         q_out = q_out + 32'sd1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      stage_in = stage_ff;
      term_in  = term_ff;
      x_in     = x_ff;
      hp_h_in  = hp_h_ff;
      lp_h_in  = lp_h_ff;
      res_in   = res_ff;
      mul_v_in = 1'b0;
      mtag_in  = issue_tag;
      prod_in  = op_coef * op_data;
      rnd_v_in = mul_v_ff;
      rtag_in  = mtag_ff;
      rnd_in   = mtag_ff.mid ? rnd_mid[TERM_W-1:0] : rnd_full[TERM_W-1:0];
      acc_in   = acc_ff;

      if (rnd_v_ff) begin
         if (rtag_ff.first) begin
            acc_in = rtag_ff.neg ? -term_ext : term_ext;
         end else begin
            acc_in = rtag_ff.neg ? acc_ff - term_ext : acc_ff + term_ext;
         end
      end

      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               x_in     = x_scaled;
               stage_in = 1'b0;
               term_in  = TERM_X0;
               phase_in = PH_ISSUE;
               if (clear) begin
                  for (int k = 0; k < 4; k++) begin
                     hp_h_in[k] = 32'sd0;
                     lp_h_in[k] = 32'sd0;
                  end
               end
            end
         end
         PH_ISSUE: begin
            mul_v_in = 1'b1;
            term_in  = term_ff + 3'd1;
            if (term_ff == TERM_Y2) begin
               phase_in = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (rnd_v_ff && rtag_ff.last) begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            // Shift the history and feed this filter's output onward
            x_in = y_sat;
            if (stage_ff) begin
               lp_h_in[1] = lp_h_ff[0];
               lp_h_in[0] = x_ff;
               lp_h_in[3] = lp_h_ff[2];
               lp_h_in[2] = y_sat;
               phase_in   = PH_OUT;
            end else begin
               hp_h_in[1] = hp_h_ff[0];
               hp_h_in[0] = x_ff;
               hp_h_in[3] = hp_h_ff[2];
               hp_h_in[2] = y_sat;
               stage_in   = 1'b1;
               term_in    = TERM_X0;
               phase_in   = PH_ISSUE;
            end
         end
         PH_OUT: begin
            if (q_out > 32'sd32767) begin
               res_in = 16'sh7fff;
            end else if (q_out < -32'sd32768) begin
               res_in = 16'sh8000;
            end else begin
               res_in = q_out[15:0];
            end
            phase_in = PH_HOLD;
         end
         PH_HOLD: begin
            if (ack) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stage_ff <= 1'b0;
         term_ff  <= TERM_X0;
         mul_v_ff <= 1'b0;
         rnd_v_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            hp_h_ff[k] <= 32'sd0;
            lp_h_ff[k] <= 32'sd0;
         end
      end else begin
         phase_ff <= phase_in;
         stage_ff <= stage_in;
         term_ff  <= term_in;
         mul_v_ff <= mul_v_in;
         rnd_v_ff <= rnd_v_in;
         hp_h_ff  <= hp_h_in;
         lp_h_ff  <= lp_h_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      mtag_ff <= mtag_in;
      prod_ff <= prod_in;
      rtag_ff <= rtag_in;
      rnd_ff  <= rnd_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign stat.idle      = (phase_ff == PH_IDLE);
   assign stat.res_valid = (phase_ff == PH_HOLD);
   assign result         = res_ff;

endmodule

`default_nettype wire

>>> src/shb_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module shb_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire shb_pkg::lane_stat_type left_stat,
   input  wire shb_pkg::lane_stat_type right_stat,
   input  wire logic signed [15:0]     left_res,
   input  wire logic signed [15:0]     right_res,
   input  wire logic                   rsp_stall,
   output logic                        lane_ack,
   output logic                        rsp_valid,
   output logic signed [15:0]          rsp_left_filtered,
   output logic signed [15:0]          rsp_right_filtered
);
   import shb_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;
   logic               load;

   // Take the pair once both lanes hold a result and the slot is free
   assign load = left_stat.res_valid && right_stat.res_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         left_in  = left_res;
         right_in = right_res;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign lane_ack           = load;
   assign rsp_valid          = valid_ff;
   assign rsp_left_filtered  = left_ff;
   assign rsp_right_filtered = right_ff;

endmodule

`default_nettype wire

>>> src/stereo_highpass_lowpass_biquad.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_highpass_lowpass_biquad_defines.svh"

// Stereo filter: each 16-bit channel runs through a high-pass biquad and
// then a low-pass biquad, both direct form I, with coefficients in Q2.30
// shared by the two channels (b1 and b2 follow from b0 as in the cookbook
// forms). Left and right run in two identical lanes side by side; each lane
// owns one 32x32 multiplier and feeds the five products of a biquad
// through it one a cycle. Each biquad issues its five products, lets the
// last of them pass the product, rounding and accumulator registers, and
// then saturates the sum and shifts the history. After the low-pass stage
// the lane forms the output sample, which the merge loads into the output
// register. A lane takes no new sample while one is in flight: the next
// pair is taken once both lanes have handed their result to the output
// register, so a stalled result holds the input side for at most one more
// pair. Coefficient writes go through the csr port, which is always ready;
// write them only while no pair is in flight. Indexes past the last
// register are dropped. A pair with clear_history set zeroes all filter
// history first.
module stereo_highpass_lowpass_biquad (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample pair in
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [15:0]             req_left_sample,
   input  wire logic signed [15:0]             req_right_sample,
   input  wire logic                           req_clear_history,
   // filtered pair out
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [15:0]                  rsp_left_filtered,
   output logic signed [15:0]                  rsp_right_filtered,
   // coefficient writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [shb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_wdata
);
   import shb_pkg::*;

   coef_type       coef_ff, coef_in;
   lane_stat_type  left_stat, right_stat;
   logic signed [15:0] left_res, right_res;
   logic           lane_ack;
   logic           req_accept;
   logic           both_done;

   // Coefficient registers; a write to an unknown index changes nothing
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HP_NUM_GAIN: coef_in.hp_b0 = csr_wdata;
            REG_HP_FB_ONE:   coef_in.hp_a1 = csr_wdata;
            REG_HP_FB_TWO:   coef_in.hp_a2 = csr_wdata;
            REG_LP_NUM_GAIN: coef_in.lp_b0 = csr_wdata;
            REG_LP_FB_ONE:   coef_in.lp_a1 = csr_wdata;
            REG_LP_FB_TWO:   coef_in.lp_a2 = csr_wdata;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Hold the input side until both lanes are free again
   assign req_stall  = !(left_stat.idle && right_stat.idle);
   assign req_accept = req_valid && !req_stall;

   shb_lane u_left (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .sample (req_left_sample),
      .clear  (req_clear_history),
      .coef   (coef_ff),
      .ack    (lane_ack),
      .stat   (left_stat),
      .result (left_res)
   );

   shb_lane u_right (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .sample (req_right_sample),
      .clear  (req_clear_history),
      .coef   (coef_ff),
      .ack    (lane_ack),
      .stat   (right_stat),
      .result (right_res)
   );

   // Join both lanes into one output transfer
   shb_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .left_stat          (left_stat),
      .right_stat         (right_stat),
      .left_res           (left_res),
      .right_res          (right_res),
      .rsp_stall          (rsp_stall),
      .lane_ack           (lane_ack),
      .rsp_valid          (rsp_valid),
      .rsp_left_filtered  (rsp_left_filtered),
      .rsp_right_filtered (rsp_right_filtered)
   );

   assign both_done = left_stat.res_valid && right_stat.res_valid;

   // Lanes start together and must stay in lock step
   `SHB_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "lanes idle after transfer in")
   `SHB_ASSERT_HOLDS(a_lanes_in_step, left_stat.res_valid == right_stat.res_valid, "lane skew")
   `SHB_ASSERT_IMP(a_ack_needs_both, lane_ack, both_done, "ack without result")

endmodule

`default_nettype wire

>>> sim/biquad_pair_checker.sv
`timescale 1ns / 1ps

module biquad_pair_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic signed [15:0]             req_left_sample,
   input  wire logic signed [15:0]             req_right_sample,
   input  wire logic                           req_clear_history,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic signed [15:0]             rsp_left_filtered,
   input  wire logic signed [15:0]             rsp_right_filtered,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [shb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_wdata,
   output int                                  pending,
   output int                                  mismatches,
   output int                                  checked
);
   import shb_pkg::*;

   localparam int STAGE_HIGHPASS = 0;
   localparam int STAGE_LOWPASS  = 1;
   localparam int CH_LEFT        = 0;
   localparam int CH_RIGHT       = 1;
   localparam int TAP_X1         = 0;
   localparam int TAP_X2         = 1;
   localparam int TAP_Y1         = 2;
   localparam int TAP_Y2         = 3;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } filtered_pair_type;

   coef_type                  coefs;
   logic signed [31:0]        taps [2][2][4];   // [stage][channel][tap]
   filtered_pair_type         filtered_due [$];
   int                        fail_tally;
   int                        compare_tally;

   // Product rounded half up, dropping s fractional bits.
   function automatic longint rounded_term(input longint coef, input longint x, input int s);
      return (coef * x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] filter_stage(input int stg, input int ch,
                                                      input logic signed [31:0] x0);
      longint b0, a1, a2, mid, acc;
      logic signed [31:0] y;
      if (stg == STAGE_HIGHPASS) begin
         b0 = $signed(coefs.hp_b0);
         a1 = $signed(coefs.hp_a1);
         a2 = $signed(coefs.hp_a2);
      end else begin
         b0 = $signed(coefs.lp_b0);
         a1 = $signed(coefs.lp_a1);
         a2 = $signed(coefs.lp_a2);
      end
      // b1 = -/+ 2*b0: one fractional bit less instead of a doubled coefficient
      mid = rounded_term(b0, taps[stg][ch][TAP_X1], COEF_FRAC_BITS - 1);
      acc = rounded_term(b0, x0, COEF_FRAC_BITS);
      acc += (stg == STAGE_HIGHPASS) ? -mid : mid;
      acc += rounded_term(b0, taps[stg][ch][TAP_X2], COEF_FRAC_BITS);
      acc -= rounded_term(a1, taps[stg][ch][TAP_Y1], COEF_FRAC_BITS);
      acc -= rounded_term(a2, taps[stg][ch][TAP_Y2], COEF_FRAC_BITS);
      if (acc > WORD_MAX)
         acc = WORD_MAX;
      else if (acc < WORD_MIN)
         acc = WORD_MIN;
      y = 32'(acc);
      taps[stg][ch][TAP_X2] = taps[stg][ch][TAP_X1];
      taps[stg][ch][TAP_X1] = x0;
      taps[stg][ch][TAP_Y2] = taps[stg][ch][TAP_Y1];
      taps[stg][ch][TAP_Y1] = y;
      return y;
   endfunction

   function automatic logic signed [15:0] filter_channel(input int ch,
                                                        input logic signed [15:0] pcm);
      logic signed [31:0] scaled, hp_y, lp_y;
      longint v, t;
      scaled = 32'(longint'(pcm) <<< GUARD_FRAC_BITS);
      hp_y = filter_stage(STAGE_HIGHPASS, ch, scaled);
      lp_y = filter_stage(STAGE_LOWPASS, ch, hp_y);
      // truncate toward zero, then clamp to 16 bits
      v = lp_y;
      t = (v >= 0) ? (v >>> GUARD_FRAC_BITS) : -((-v) >>> GUARD_FRAC_BITS);
      if (t > 32767)
         t = 32767;
      else if (t < -32768)
         t = -32768;
      return 16'(t);
   endfunction

   always @(posedge clock) begin : watch
      filtered_pair_type want;
      if (reset) begin
         coefs = '0;
         taps = '{default: '0};
         filtered_due.delete();
         fail_tally = 0;
         compare_tally = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HP_NUM_GAIN: coefs.hp_b0 = csr_wdata;
               REG_HP_FB_ONE:   coefs.hp_a1 = csr_wdata;
               REG_HP_FB_TWO:   coefs.hp_a2 = csr_wdata;
               REG_LP_NUM_GAIN: coefs.lp_b0 = csr_wdata;
               REG_LP_FB_ONE:   coefs.lp_a1 = csr_wdata;
               REG_LP_FB_TWO:   coefs.lp_a2 = csr_wdata;
               default: ;
            endcase
         end
         // retire the oldest expectation before adding a new one
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               $display("%0t: filtered pair %0d/%0d arrived with nothing expected",
                        $time, rsp_left_filtered, rsp_right_filtered);
               fail_tally++;
            end else begin
               want = filtered_due.pop_front();
               compare_tally++;
               if (rsp_left_filtered !== want.left) begin
                  $display("%0t: left_filtered expected %0d, actual %0d",
                           $time, want.left, rsp_left_filtered);
                  fail_tally++;
               end
               if (rsp_right_filtered !== want.right) begin
                  $display("%0t: right_filtered expected %0d, actual %0d",
                           $time, want.right, rsp_right_filtered);
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_clear_history)
               taps = '{default: '0};
            want.left  = filter_channel(CH_LEFT, req_left_sample);
            want.right = filter_channel(CH_RIGHT, req_right_sample);
            filtered_due.push_back(want);
         end
      end
      pending    <= filtered_due.size();
      mismatches <= fail_tally;
      checked    <= compare_tally;
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import shb_pkg::*;

   // Indexes past the register map; the block must drop these writes.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int PHASE_ITEMS  = 200;
   localparam int DRAIN_SLACK  = 30;     // extra wait after the last expected pair is out
   localparam int LONG_HOLD    = 400;    // receiver hold-off, in cycles
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [15:0]    req_left_sample;
   logic signed [15:0]    req_right_sample;
   logic                  req_clear_history;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [15:0]    rsp_left_filtered;
   logic signed [15:0]    rsp_right_filtered;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [31:0]           csr_wdata;

   int pending;
   int mismatches;
   int checked;
   int squeeze_asks;
   int pairs_sent;
   int clears_sent;
   int coef_sets;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   stereo_highpass_lowpass_biquad uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_clear_history  (req_clear_history),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_filtered  (rsp_left_filtered),
      .rsp_right_filtered (rsp_right_filtered),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Predict and compare beside the block; hand back the tallies.
   biquad_pair_checker scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_clear_history  (req_clear_history),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_filtered  (rsp_left_filtered),
      .rsp_right_filtered (rsp_right_filtered),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pending            (pending),
      .mismatches         (mismatches),
      .checked            (checked)
   );

   function automatic coef_type coef_set(input logic [31:0] hb0, ha1, ha2, lb0, la1, la2);
      coef_type c;
      c.hp_b0 = hb0;
      c.hp_a1 = ha1;
      c.hp_a2 = ha2;
      c.lp_b0 = lb0;
      c.lp_a1 = la1;
      c.lp_a2 = la2;
      return c;
   endfunction

   // Coefficient within +/-0.5, where stable filters live.
   function automatic logic [31:0] moderate_coef();
      logic [31:0] r;
      r = $urandom();
      return {{2{r[29]}}, r[29:0]};
   endfunction

   // Mix of rail values, quiet signal and full-range noise.
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         1, 2:    return 16'($urandom_range(2047)) - 16'sd1024;
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one pair at the falling edge; hold it until the block takes it.
   task automatic send_pair(input logic signed [15:0] l, r, input logic clr);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_left_sample   <= l;
      req_right_sample  <= r;
      req_clear_history <= clr;
      do @(posedge clock); while (req_stall);
      pairs_sent++;
      if (clr)
         clears_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Random bursts with random gaps; gap_max of zero keeps valid high throughout.
   task automatic send_stream(input int count, input int gap_max);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(24, 1);
            if (gap_max > 0)
               pause_sender($urandom_range(gap_max));
         end
         send_pair(pick_sample(), pick_sample(), $urandom_range(31) == 0);
         burst--;
      end
   endtask

   // Drop valid, then wait for every filtered pair plus a little slack.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reprogram only once the pipeline is empty.
   task automatic load_coefs(input coef_type c);
      wait_drained();
      write_reg(REG_HP_NUM_GAIN, c.hp_b0);
      write_reg(REG_HP_FB_ONE,   c.hp_a1);
      write_reg(REG_HP_FB_TWO,   c.hp_a2);
      write_reg(REG_LP_NUM_GAIN, c.lp_b0);
      write_reg(REG_LP_FB_ONE,   c.lp_a1);
      write_reg(REG_LP_FB_TWO,   c.lp_a2);
      write_reg(CSR_SPARE_LO, $urandom());
      write_reg(CSR_SPARE_HI, $urandom());
      @(negedge clock);
      csr_valid <= 1'b0;
      coef_sets++;
   endtask

   // Receiver: stall on a pattern of its own, switching modes every so often;
   // on request, hold off for a long stretch so the block backs up.
   initial begin : receiver
      int             served;
      int             mode_left;
      stall_mode_type mode;
      served    = 0;
      mode_left = 0;
      mode      = STALL_NONE;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (served != squeeze_asks) begin
            served = squeeze_asks;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(3));
               mode_left = $urandom_range(300, 40);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(9) < 7);
               default:     rsp_stall <= ((mode_left % 7) < 3);
            endcase
         end
      end
   end

   initial begin : stimulus
      coef_type audio_set, max_set, min_set;
      audio_set = coef_set(32'sd1063862000, -32'sd2127602000, 32'sd1053985000,
                           32'sd166480000, -32'sd665930000, 32'sd258130000);
      max_set = coef_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      min_set = coef_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

      // Drive every input to a known value before the first edge.
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_left_sample   = '0;
      req_right_sample  = '0;
      req_clear_history = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      squeeze_asks      = 0;
      pairs_sent        = 0;
      clears_sent       = 0;
      coef_sets         = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Coefficients still at reset: everything filters to zero.
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b0);

      // Realistic audio corner frequencies; rails, sign flips, bit patterns, clears.
      load_coefs(audio_set);
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_pair(16'sh8000, 16'sh8000, 1'b0);
      send_pair(16'sh8000, 16'sh8000, 1'b1);   // clear together with a sample
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sh5555, 16'shAAAA, 1'b0);
      send_pair(16'shAAAA, 16'sh5555, 1'b0);
      send_pair(16'sd12345, -16'sd12345, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);

      // Rail coefficients: drive the accumulator and the output into saturation.
      load_coefs(max_set);
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      load_coefs(min_set);
      send_pair(16'sh8000, 16'sh8000, 1'b0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b1);

      // Random traffic, one coefficient set per phase.  The first phase starts
      // with a long receiver hold-off while valid stays high.
      load_coefs(audio_set);
      squeeze_asks++;
      send_stream(80, 0);
      send_stream(PHASE_ITEMS - 80, 12);

      load_coefs(max_set);
      send_stream(PHASE_ITEMS, 6);

      load_coefs(coef_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_stream(PHASE_ITEMS, 0);

      load_coefs(coef_set($urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()));
      send_stream(PHASE_ITEMS, 12);

      load_coefs(coef_set(moderate_coef(), moderate_coef(), moderate_coef(),
                          moderate_coef(), moderate_coef(), moderate_coef()));
      send_stream(PHASE_ITEMS, 3);

      load_coefs(min_set);
      send_stream(PHASE_ITEMS, 8);

      load_coefs(coef_set('0, '0, '0, '0, '0, '0));
      send_stream(PHASE_ITEMS / 2, 4);

      load_coefs(coef_set($urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()));
      send_stream(PHASE_ITEMS / 2, 10);

      // Let the last results come out, then give the verdict.
      wait_drained();
      @(negedge clock);
      $display("Sent %0d sample pairs (%0d with history clear) over %0d coefficient sets;",
               pairs_sent, clears_sent, coef_sets);
      $display("compared %0d filtered pairs, including rail coefficients and a long hold-off.",
               checked);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d filtered pairs outstanding", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/shb_pkg.sv
src/shb_lane.sv
src/shb_merge.sv
src/stereo_highpass_lowpass_biquad.sv
sim/biquad_pair_checker.sv
sim/tb.sv
